// File: design/dbpm_pkg.sv
// ----------------------------------------------------------------------------
// dbpm_pkg
// Shared widths, command codes and register indexes of the decay background
// pattern mixer.
// ----------------------------------------------------------------------------
package dbpm_pkg;

  localparam int unsigned BINS      = 4096;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned NUM_W     = FRAC_W + SUM_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] CMD_LOAD_PAT   = 2'd0;
  localparam logic [1:0] CMD_LOAD_DECAY = 2'd1;
  localparam logic [1:0] CMD_READ       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIX_FRACTION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_LENGTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd5;

endpackage

// File: design/dbpm_div.sv
// ----------------------------------------------------------------------------
// dbpm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbpm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dbpm_pkg::NUM_W-1:0]   numer,
  input  logic [dbpm_pkg::SUM_W-1:0]   denom,
  output logic                         done,
  output logic [dbpm_pkg::NUM_W-1:0]   quot
);
  import dbpm_pkg::*;

  logic               run_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic [NUM_W-1:0]   quo_r;
  logic [SUM_W-1:0]   rem_r;
  logic [SUM_W-1:0]   den_r;
  logic [SUM_W:0]     rem_sh;
  logic [SUM_W:0]     diff;
  logic               ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= 6'(NUM_W);
      quo_r <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (run_r) begin
      rem_r <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// File: design/decay_background_pattern_mixer.sv
// ----------------------------------------------------------------------------
// decay_background_pattern_mixer
// Pattern and decay bin stores with windowed mixing of the pattern curve.
// ----------------------------------------------------------------------------
// Usage: a command transfers when start is high and busy is low. Load
// commands write one bin into the pattern or decay store and give no result.
// A read returns one result: out_valid is high for exactly one cycle with
// the index, mixed value and flags; the receiver cannot stall. With a
// current scale a read passes through S_RD, S_MUL and S_FIN. After any load or
// register write, the next read first sweeps the window, one bin per cycle
// through the store read ports, forms the product and, unless the mix
// fraction or pattern sum is zero, runs the bit-serial divider before the
// bin read. Register writes take effect at once; issue them only while busy
// is low, as the block does not enforce it. After reset the pattern store is
// cleared one entry per cycle, busy high; register writes are taken meanwhile.
// ----------------------------------------------------------------------------
module decay_background_pattern_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_cmd,
  input  logic [dbpm_pkg::IDX_W-1:0]        in_bin_index,
  input  logic [dbpm_pkg::SMP_W-1:0]        in_sample,
  input  logic                              cfg_we,
  input  logic [dbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbpm_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  output logic [dbpm_pkg::IDX_W-1:0]        out_index,
  output logic signed [31:0]                out_mixed_value,
  output logic                              out_saturated,
  output logic                              out_zero_pattern_sum
);
  import dbpm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SUM, S_SCALE, S_DIV, S_RD, S_MUL, S_FIN
  } state_t;

  state_t               state_r;
  logic [IDX_W-1:0]     clr_ptr_r;
  logic [IDX_W:0]       ptr_r;
  logic                 rdv_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SUM_W-1:0]     ds_r;
  logic [SUM_W-1:0]     bs_r;
  logic [NUM_W-1:0]     scale_r;
  logic                 scale_valid_r;

  logic [FRAC_W-1:0]    frac_r;
  logic signed [CFG_W-1:0] offset_r;
  logic [IDX_W:0]       wstart_r;
  logic [IDX_W:0]       wstop_r;
  logic [IDX_W:0]       clen_r;
  logic                 enable_r;

  logic [SMP_W-1:0]     pat_mem [BINS];
  logic [SMP_W-1:0]     dec_mem [BINS];
  logic [SMP_W-1:0]     pat_rdata_r;
  logic [SMP_W-1:0]     dec_rdata_r;

  logic [FRAC_W+SMP_W-1:0] a_r;
  logic [NUM_W+SMP_W-1:0]  b_r;
  logic [SMP_W-1:0]     bin_r;
  logic                 win_r;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_index_r;
  logic signed [31:0]   out_value_r;
  logic                 out_sat_r;
  logic                 out_zero_r;

  logic                 accept;
  logic                 pat_we;
  logic                 dec_we;
  logic [IDX_W-1:0]     pat_waddr;
  logic [SMP_W-1:0]     pat_wdata;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W:0]       len;
  logic [IDX_W:0]       lo;
  logic [IDX_W:0]       hi;
  logic                 windowed;
  logic [SUM_W:0]       ds_add;
  logic [SUM_W:0]       bs_add;
  logic [NUM_W-1:0]     numer;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic [NUM_W+SMP_W:0] acc;
  logic signed [55:0]   val;
  logic                 sat_hi;
  logic                 sat_lo;
  logic [FRAC_W-1:0]    frac_nxt;

  assign accept = start && (state_r == S_IDLE);

  assign len = (clen_r > 13'(BINS)) ? 13'(BINS) : clen_r;
  assign lo  = (wstart_r > len) ? len : wstart_r;
  assign hi  = (wstop_r > len) ? len : wstop_r;
  assign windowed = enable_r && ({1'b0, idx_r} >= lo) && ({1'b0, idx_r} < hi);

  assign pat_we    = (state_r == S_CLEAR) || (accept && in_cmd == CMD_LOAD_PAT);
  assign dec_we    = accept && in_cmd == CMD_LOAD_DECAY;
  assign pat_waddr = (state_r == S_CLEAR) ? clr_ptr_r : in_bin_index;
  assign pat_wdata = (state_r == S_CLEAR) ? '0 : in_sample;
  assign rd_addr   = (state_r == S_SUM) ? ptr_r[IDX_W-1:0] : idx_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    pat_rdata_r <= pat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dec_we) begin
      dec_mem[in_bin_index] <= in_sample;
    end
    dec_rdata_r <= dec_mem[rd_addr];
  end

  assign ds_add = {1'b0, ds_r} + {13'b0, dec_rdata_r};
  assign bs_add = {1'b0, bs_r} + {13'b0, pat_rdata_r};

  assign numer     = frac_r * ds_r;
  assign div_start = (state_r == S_SCALE) && (frac_r != '0) && (bs_r != '0);

  dbpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (bs_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign acc    = {29'b0, a_r} + {1'b0, b_r} + 62'd128;
  assign val    = win_r ? ($signed({2'b0, acc[NUM_W+SMP_W:8]}) +
                           {{32{offset_r[CFG_W-1]}}, offset_r})
                        : $signed({32'b0, bin_r, 8'b0});
  assign sat_hi = !val[55] && (val[54:31] != '0);
  assign sat_lo = val[55] && (val[54:31] != '1);

  assign frac_nxt = (cfg_wdata[FRAC_W-1:0] > ONE_Q16) ? ONE_Q16 : cfg_wdata[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_ptr_r     <= '0;
      rdv_r         <= 1'b0;
      scale_valid_r <= 1'b0;
      ds_r          <= '0;
      bs_r          <= '0;
      scale_r       <= '0;
      frac_r        <= '0;
      offset_r      <= '0;
      wstart_r      <= '0;
      wstop_r       <= 13'(BINS);
      clen_r        <= 13'(BINS);
      enable_r      <= 1'b1;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_ptr_r <= clr_ptr_r + 1'b1;
          if (clr_ptr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (in_cmd)
              CMD_LOAD_PAT, CMD_LOAD_DECAY: scale_valid_r <= 1'b0;
              CMD_READ: begin
                idx_r <= in_bin_index;
                if (scale_valid_r) begin
                  state_r <= S_RD;
                end else begin
                  state_r <= S_SUM;
                  ptr_r   <= lo;
                  rdv_r   <= 1'b0;
                  ds_r    <= '0;
                  bs_r    <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          if (ptr_r < hi) begin
            ptr_r <= ptr_r + 1'b1;
            rdv_r <= 1'b1;
          end else begin
            rdv_r <= 1'b0;
          end
          if (rdv_r) begin
            ds_r <= ds_add[SUM_W] ? '1 : ds_add[SUM_W-1:0];
            bs_r <= bs_add[SUM_W] ? '1 : bs_add[SUM_W-1:0];
          end
          if (ptr_r >= hi && !rdv_r) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (div_start) begin
            state_r <= S_DIV;
          end else begin
            scale_r       <= '0;
            scale_valid_r <= 1'b1;
            state_r       <= S_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            scale_r       <= div_quot;
            scale_valid_r <= 1'b1;
            state_r       <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          a_r     <= dec_rdata_r * (ONE_Q16 - frac_r);
          b_r     <= pat_rdata_r * scale_r;
          bin_r   <= dec_rdata_r;
          win_r   <= windowed;
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_index_r <= idx_r;
          out_value_r <= sat_hi ? 32'sh7FFFFFFF : (sat_lo ? 32'sh80000000 : val[31:0]);
          out_sat_r   <= sat_hi || sat_lo;
          out_zero_r  <= win_r && (frac_r != '0) && (bs_r == '0);
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_index)
          REG_MIX_FRACTION:    frac_r   <= frac_nxt;
          REG_CONSTANT_OFFSET: offset_r <= cfg_wdata;
          REG_WINDOW_START:    wstart_r <= cfg_wdata[IDX_W:0];
          REG_WINDOW_STOP:     wstop_r  <= cfg_wdata[IDX_W:0];
          REG_CURVE_LENGTH:    clen_r   <= cfg_wdata[IDX_W:0];
          REG_ENABLE:          enable_r <= cfg_wdata[0];
          default: ;
        endcase
        if (cfg_index <= REG_ENABLE) begin
          scale_valid_r <= 1'b0;
        end
      end
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_index            = out_index_r;
  assign out_mixed_value      = out_value_r;
  assign out_saturated        = out_sat_r;
  assign out_zero_pattern_sum = out_zero_r;

endmodule
